// ===== hw/rtl/scng_pkg.sv =====
// package for the sound chip noise generator: codes, constants, types and
// small helper functions. no dependencies.
package scng_pkg;

   localparam int unsigned COUNT_W = 25;
   localparam int unsigned GEN_W   = 32;

   localparam logic [COUNT_W-1:0] STEP_BASE  = 25'd8000000;
   localparam logic [COUNT_W-1:0] RATE_BASE  = 25'd11289600;
   localparam logic [GEN_W-1:0]   LCG_MUL    = 32'd110351245;
   localparam logic [GEN_W-1:0]   LCG_ADD    = 32'd12345;
   localparam logic [GEN_W-1:0]   LEVEL_EDGE = 32'h8000_0000;
   localparam logic [GEN_W-1:0]   SEED_RESET = 32'h1111_1111;

   localparam logic [1:0] RATE_MODE_RESET = 2'd2;
   localparam logic [1:0] RATE_MODE_MAX   = 2'd2;
   localparam logic [1:0] SOURCE_TRIGGER  = 2'd3;

   localparam logic GEN_LCG  = 1'b0;
   localparam logic GEN_LFSR = 1'b1;

   // register indexes of the write port
   localparam logic [1:0] CSR_SOURCE_MODE = 2'd0;
   localparam logic [1:0] CSR_GEN_KIND    = 2'd1;
   localparam logic [1:0] CSR_SEED        = 2'd2;

   typedef enum logic [1:0] {
      KIND_TICK    = 2'd0,
      KIND_TRIGGER = 2'd1,
      KIND_SYNC    = 2'd2,
      KIND_RATE    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_TEST,
      ST_MUL,
      ST_FIN,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      PH_HOLD,
      PH_APPLY,
      PH_SUB
   } ph_op_type;

   typedef struct packed {
      ph_op_type ph_op;
      logic      gen_mul;
      logic      gen_fin;
      logic      rsp_load;
   } ctl_type;

   // counter step per tick for source modes 0..2
   function automatic logic [COUNT_W-1:0] step_of(input logic [1:0] mode);
      return STEP_BASE >> mode;
   endfunction

   // wrap threshold for sample-rate modes 0..2
   function automatic logic [COUNT_W-1:0] threshold_of(input logic [1:0] mode);
      return RATE_BASE >> mode;
   endfunction

endpackage

// ===== hw/rtl/scng_phase_unit.sv =====
// phase counter with its shared add/subtract and threshold compare,
// plus sync flag and sample-rate mode. depends on scng_pkg.
module scng_phase_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  scng_pkg::ph_op_type           ph_op,
   input  scng_pkg::kind_type            item_kind,
   input  logic                          item_sync_on,
   input  logic [1:0]                    item_rate_mode,
   input  logic [1:0]                    source_mode,
   output logic                          ge,
   output logic                          sync_flag
);

   logic [scng_pkg::COUNT_W-1:0] pc_ff, pc_in;
   logic                         sync_ff, sync_in;
   logic [1:0]                   rate_ff, rate_in;

   logic [scng_pkg::COUNT_W-1:0] thr;
   logic [scng_pkg::COUNT_W-1:0] addend;
   logic [scng_pkg::COUNT_W-1:0] sum;
   logic [scng_pkg::COUNT_W-1:0] rescaled;
   logic [1:0]                   new_mode;

   assign thr    = scng_pkg::threshold_of(rate_ff);
   assign ge     = (pc_ff >= thr);
   // one adder: step on a tick, minus threshold on a wrap
   assign addend = (ph_op == scng_pkg::PH_SUB) ? (~thr + 25'd1)
                                               : scng_pkg::step_of(source_mode);
   assign sum    = pc_ff + addend;

   assign new_mode = (item_rate_mode > scng_pkg::RATE_MODE_MAX) ? scng_pkg::RATE_MODE_MAX
                                                                : item_rate_mode;
   always_comb begin
      if (new_mode < rate_ff) begin
         rescaled = pc_ff << (rate_ff - new_mode);
      end else begin
         rescaled = pc_ff >> (new_mode - rate_ff);
      end
   end

   always_comb begin
      pc_in   = pc_ff;
      sync_in = sync_ff;
      rate_in = rate_ff;
      case (ph_op)
         scng_pkg::PH_APPLY: begin
            case (item_kind)
               scng_pkg::KIND_TICK: begin
                  pc_in = sum;
               end
               scng_pkg::KIND_SYNC: begin
                  if (item_sync_on) begin
                     pc_in = '0;
                  end
                  sync_in = item_sync_on;
               end
               scng_pkg::KIND_RATE: begin
                  pc_in   = rescaled;
                  rate_in = new_mode;
               end
               default: begin
               end
            endcase
         end
         scng_pkg::PH_SUB: begin
            pc_in = sum;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= '0;
         sync_ff <= 1'b0;
         rate_ff <= scng_pkg::RATE_MODE_RESET;
      end else begin
         pc_ff   <= pc_in;
         sync_ff <= sync_in;
         rate_ff <= rate_in;
      end
   end

   assign sync_flag = sync_ff;

`ifndef SYNTHESIS
   a_sub_only_when_ge: assert property (@(posedge clock) disable iff (reset)
      (ph_op == scng_pkg::PH_SUB) |-> ge)
      else $error("counter subtract below threshold");
   a_rate_in_range: assert property (@(posedge clock) disable iff (reset)
      (ph_op == scng_pkg::PH_APPLY && item_kind == scng_pkg::KIND_RATE)
      |=> (rate_ff <= scng_pkg::RATE_MODE_MAX))
      else $error("rate mode out of range");
   a_sync_clears: assert property (@(posedge clock) disable iff (reset)
      (ph_op == scng_pkg::PH_APPLY && item_kind == scng_pkg::KIND_SYNC && item_sync_on)
      |=> (pc_ff == '0))
      else $error("sync on did not clear counter");
`endif

endmodule

// ===== hw/rtl/scng_gen_unit.sv =====
// noise generator state: congruential multiply or feedback shift, done in
// two steps through a product register. depends on scng_pkg.
module scng_gen_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        gen_kind,
   input  logic                        seed_we,
   input  logic [scng_pkg::GEN_W-1:0]  seed_value,
   input  logic                        gen_mul,
   input  logic                        gen_fin,
   output logic                        level
);

   logic [scng_pkg::GEN_W-1:0] gen_ff, gen_in;
   logic [scng_pkg::GEN_W-1:0] prod_ff, prod_in;
   logic                       held_ff, held_in;
   logic [scng_pkg::GEN_W-1:0] mul_lo;

   assign mul_lo = gen_ff * scng_pkg::LCG_MUL;

   always_comb begin
      prod_in = prod_ff;
      held_in = held_ff;
      gen_in  = gen_ff;
      if (gen_mul) begin
         if (gen_kind == scng_pkg::GEN_LCG) begin
            prod_in = mul_lo;
            held_in = (gen_ff > scng_pkg::LEVEL_EDGE);
         end else begin
            prod_in = {gen_ff[scng_pkg::GEN_W-2:0], gen_ff[30] ^ gen_ff[2]};
         end
      end
      if (gen_fin) begin
         gen_in = (gen_kind == scng_pkg::GEN_LCG) ? (prod_ff + scng_pkg::LCG_ADD) : prod_ff;
      end
      if (seed_we) begin
         gen_in = seed_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff  <= scng_pkg::SEED_RESET;
         held_ff <= 1'b0;
      end else begin
         gen_ff  <= gen_in;
         held_ff <= held_in;
      end
      prod_ff <= prod_in;
   end

   assign level = (gen_kind == scng_pkg::GEN_LFSR) ? gen_ff[0] : held_ff;

`ifndef SYNTHESIS
   a_fin_after_mul: assert property (@(posedge clock) disable iff (reset)
      gen_fin |-> $past(gen_mul))
      else $error("generator finish without multiply step");
   a_held_only_on_mul: assert property (@(posedge clock) disable iff (reset)
      !gen_mul |=> $stable(held_ff))
      else $error("held level changed outside an advance");
   a_lfsr_shift: assert property (@(posedge clock) disable iff (reset)
      (gen_mul && gen_kind == scng_pkg::GEN_LFSR) |=> (prod_ff[0] ==
      ($past(gen_ff[30]) ^ $past(gen_ff[2]))))
      else $error("shift register feedback wrong");
`endif

endmodule

// ===== hw/rtl/scng_seq.sv =====
// sequencer: steps one word through counter add, threshold tests and
// generator advances. depends on scng_pkg.
module scng_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_fire,
   input  scng_pkg::kind_type   req_kind,
   input  scng_pkg::kind_type   item_kind,
   input  logic                 sync_flag,
   input  logic [1:0]           source_mode,
   input  logic                 ge,
   input  logic                 rsp_free,
   output logic                 idle,
   output scng_pkg::ctl_type    ctl
);

   scng_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scng_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_kind)
                  scng_pkg::KIND_TICK: begin
                     state_in = (!sync_flag && source_mode != scng_pkg::SOURCE_TRIGGER)
                                ? scng_pkg::ST_ADD : scng_pkg::ST_DONE;
                  end
                  scng_pkg::KIND_TRIGGER: begin
                     state_in = (source_mode == scng_pkg::SOURCE_TRIGGER)
                                ? scng_pkg::ST_MUL : scng_pkg::ST_DONE;
                  end
                  default: begin
                     state_in = scng_pkg::ST_ADD;
                  end
               endcase
            end
         end
         scng_pkg::ST_ADD: begin
            state_in = (item_kind == scng_pkg::KIND_TICK) ? scng_pkg::ST_TEST
                                                          : scng_pkg::ST_DONE;
         end
         scng_pkg::ST_TEST: begin
            state_in = ge ? scng_pkg::ST_MUL : scng_pkg::ST_DONE;
         end
         scng_pkg::ST_MUL: begin
            state_in = scng_pkg::ST_FIN;
         end
         scng_pkg::ST_FIN: begin
            state_in = (item_kind == scng_pkg::KIND_TICK) ? scng_pkg::ST_TEST
                                                          : scng_pkg::ST_DONE;
         end
         scng_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = scng_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = scng_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      ctl.ph_op    = scng_pkg::PH_HOLD;
      ctl.gen_mul  = 1'b0;
      ctl.gen_fin  = 1'b0;
      ctl.rsp_load = 1'b0;
      case (state_ff)
         scng_pkg::ST_ADD: begin
            ctl.ph_op = scng_pkg::PH_APPLY;
         end
         scng_pkg::ST_TEST: begin
            ctl.ph_op = ge ? scng_pkg::PH_SUB : scng_pkg::PH_HOLD;
         end
         scng_pkg::ST_MUL: begin
            ctl.gen_mul = 1'b1;
         end
         scng_pkg::ST_FIN: begin
            ctl.gen_fin = 1'b1;
         end
         scng_pkg::ST_DONE: begin
            ctl.rsp_load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scng_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign idle = (state_ff == scng_pkg::ST_IDLE);

`ifndef SYNTHESIS
   a_mul_then_fin: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scng_pkg::ST_MUL) |=> (state_ff == scng_pkg::ST_FIN))
      else $error("advance did not finish");
   a_failed_test_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scng_pkg::ST_TEST && !ge) |=> (state_ff == scng_pkg::ST_DONE))
      else $error("failed threshold test did not end the word");
   a_leave_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scng_pkg::ST_DONE && state_in == scng_pkg::ST_IDLE) |-> ctl.rsp_load)
      else $error("word finished without a result");
`endif

endmodule

// ===== hw/rtl/sound_chip_noise_generator_unit.sv =====
// top level of the sound chip noise generator voice.
// depends on scng_pkg, scng_seq, scng_phase_unit and scng_gen_unit.
//
// noise voice: each request word is one event (sample tick, trigger pulse,
// sync on/off, sample-rate mode change) and yields exactly one response word
// carrying the noise bit after the event. words are handled one at a time by
// a small sequencer that reuses one counter adder/comparator and one
// generator advance unit (a 32x32 low-half multiply followed by a registered
// add, or a one-bit feedback shift). sync and rate words take a counter
// apply step, then the done state; a trigger in trigger mode takes one
// advance; a counting tick adds its step, then takes one advance per wrap
// (at most 3 at the supported rates), each with a threshold test, multiply
// and finish step; a trigger outside trigger mode or a tick while synced or
// in trigger mode goes straight to done. the response sits in an output
// register, so a new request is taken while a finished response still
// waits; a word that finishes while that register is still full waits in
// the done state while the receiver holds off. the user must write the
// registers through the csr port only while the voice is idle; the block
// does not enforce this. a seed write reloads the generator at once.
module sound_chip_noise_generator_unit (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] sync_on, [2:1] new_rate_mode, [7:3] zero
   input  logic [1:0]  req_tuser,   // [1:0] kind
   // response stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [0] noise_level, [7:1] zero
   // register write port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // configuration
   logic [1:0] source_mode_ff, source_mode_in;
   logic       gen_kind_ff, gen_kind_in;
   logic       seed_we;

   // latched request word
   scng_pkg::kind_type item_kind_ff, item_kind_in;
   logic               item_sync_ff, item_sync_in;
   logic [1:0]         item_mode_ff, item_mode_in;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_level_ff, rsp_level_in;

   logic              req_fire;
   logic              rsp_free;
   logic              idle;
   logic              ge;
   logic              sync_flag;
   logic              level;
   scng_pkg::ctl_type ctl;

   assign req_tready = idle;
   assign req_fire   = req_tvalid & idle;
   assign rsp_free   = ~rsp_valid_ff | rsp_tready;

   // register writes; an index past the last register is dropped
   always_comb begin
      source_mode_in = source_mode_ff;
      gen_kind_in    = gen_kind_ff;
      seed_we        = 1'b0;
      if (csr_we) begin
         case (csr_index)
            scng_pkg::CSR_SOURCE_MODE: source_mode_in = csr_wdata[1:0];
            scng_pkg::CSR_GEN_KIND:    gen_kind_in    = csr_wdata[0];
            scng_pkg::CSR_SEED:        seed_we        = 1'b1;
            default: begin
            end
         endcase
      end
   end

   // capture the request word for the sequencer and counter
   always_comb begin
      item_kind_in = item_kind_ff;
      item_sync_in = item_sync_ff;
      item_mode_in = item_mode_ff;
      if (req_fire) begin
         item_kind_in = scng_pkg::kind_type'(req_tuser);
         item_sync_in = req_tdata[0];
         item_mode_in = req_tdata[2:1];
      end
   end

   // response register: load wins over the drain of the previous word
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_level_in = rsp_level_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_level_in = level;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         source_mode_ff <= 2'd0;
         gen_kind_ff    <= scng_pkg::GEN_LCG;
         rsp_valid_ff   <= 1'b0;
      end else begin
         source_mode_ff <= source_mode_in;
         gen_kind_ff    <= gen_kind_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      item_kind_ff <= item_kind_in;
      item_sync_ff <= item_sync_in;
      item_mode_ff <= item_mode_in;
      rsp_level_ff <= rsp_level_in;
   end

   scng_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_fire    (req_fire),
      .req_kind    (scng_pkg::kind_type'(req_tuser)),
      .item_kind   (item_kind_ff),
      .sync_flag   (sync_flag),
      .source_mode (source_mode_ff),
      .ge          (ge),
      .rsp_free    (rsp_free),
      .idle        (idle),
      .ctl         (ctl)
   );

   scng_phase_unit u_phase (
      .clock          (clock),
      .reset          (reset),
      .ph_op          (ctl.ph_op),
      .item_kind      (item_kind_ff),
      .item_sync_on   (item_sync_ff),
      .item_rate_mode (item_mode_ff),
      .source_mode    (source_mode_ff),
      .ge             (ge),
      .sync_flag      (sync_flag)
   );

   scng_gen_unit u_gen (
      .clock      (clock),
      .reset      (reset),
      .gen_kind   (gen_kind_ff),
      .seed_we    (seed_we),
      .seed_value (csr_wdata),
      .gen_mul    (ctl.gen_mul),
      .gen_fin    (ctl.gen_fin),
      .level      (level)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_level_ff};

`ifndef SYNTHESIS
   a_accept_busies: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("request accepted without leaving idle");
   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |=> rsp_tvalid)
      else $error("finished word not presented");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("response overwritten before it was taken");
`endif

endmodule

// ===== test/testbench.sv =====
// self-checking testbench for sound_chip_noise_generator_unit: random and directed
// event words, an in-line noise predictor and a response scoreboard.
// depends on scng_pkg and the rtl of the noise generator voice.
`timescale 1ns / 100ps

module testbench;

   // index that decodes to no register, writes to it must be dropped
   localparam logic [1:0] CSR_UNUSED = 2'd3;

   // slowest word is a tick with three advances
   localparam int SETTLE_CYCLES  = 16;
   localparam int LONG_HOLD      = 150;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct packed {
      scng_pkg::kind_type kind;
      logic               sync_on;
      logic [1:0]         new_rate_mode;
   } noise_event_type;

   logic        clock;
   logic        reset        = 1'b1;
   logic        req_tvalid   = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata    = '0;   // [0] sync_on, [2:1] new_rate_mode, [7:3] zero
   logic [1:0]  req_tuser    = '0;   // [1:0] kind
   logic        rsp_tvalid;
   logic        rsp_tready   = 1'b0;
   logic [7:0]  rsp_tdata;           // [0] noise_level, [7:1] zero
   logic        csr_we       = 1'b0;
   logic [1:0]  csr_index    = '0;
   logic [31:0] csr_wdata    = '0;

   sound_chip_noise_generator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // noise predictor: shadow copy of the voice state and registers
   // ---------------------------------------------------------------
   logic [1:0]                   src_sel   = 2'd0;                 // source mode register
   logic                         kind_sel  = scng_pkg::GEN_LCG;    // generator kind register
   logic [scng_pkg::GEN_W-1:0]   gen_reg   = scng_pkg::SEED_RESET; // generator value
   logic [scng_pkg::COUNT_W-1:0] count_acc = '0;                   // phase counter
   logic                         lcg_bit   = 1'b0;  // level latched by the congruential kind
   logic                         sync_bit  = 1'b0;
   logic [1:0]                   rate_sel  = scng_pkg::RATE_MODE_RESET;

   // one generator step; the congruential kind latches its level from the old value
   function automatic void advance_generator();
      if (kind_sel == scng_pkg::GEN_LCG) begin
         lcg_bit = (gen_reg > scng_pkg::LEVEL_EDGE);
         gen_reg = gen_reg * scng_pkg::LCG_MUL + scng_pkg::LCG_ADD;
      end else begin
         gen_reg = {gen_reg[scng_pkg::GEN_W-2:0], gen_reg[30] ^ gen_reg[2]};
      end
   endfunction

   // applies one event word to the shadow state, returns the noise bit after it
   function automatic logic next_noise_level(input noise_event_type ev);
      logic [scng_pkg::COUNT_W-1:0] limit;
      logic [1:0]                   target;
      case (ev.kind)
         scng_pkg::KIND_TICK: begin
            // internal clock only counts while unsynced and not trigger driven
            if (!sync_bit && src_sel != scng_pkg::SOURCE_TRIGGER) begin
               limit     = scng_pkg::RATE_BASE >> rate_sel;
               count_acc = count_acc + (scng_pkg::STEP_BASE >> src_sel);
               while (count_acc >= limit) begin
                  count_acc = count_acc - limit;
                  advance_generator();
               end
            end
         end
         scng_pkg::KIND_TRIGGER: begin
            // sync has no say here, only the source mode
            if (src_sel == scng_pkg::SOURCE_TRIGGER) advance_generator();
         end
         scng_pkg::KIND_SYNC: begin
            // turning sync off keeps the counter
            if (ev.sync_on) count_acc = '0;
            sync_bit = ev.sync_on;
         end
         scng_pkg::KIND_RATE: begin
            // mode 3 folds onto the slowest rate, counter rescaled to the new threshold
            target = (ev.new_rate_mode > scng_pkg::RATE_MODE_MAX) ? scng_pkg::RATE_MODE_MAX
                                                                  : ev.new_rate_mode;
            if (target < rate_sel) count_acc = count_acc << (rate_sel - target);
            else count_acc = count_acc >> (target - rate_sel);
            rate_sel = target;
         end
         default: begin
         end
      endcase
      return (kind_sel == scng_pkg::GEN_LCG) ? lcg_bit : gen_reg[0];
   endfunction

   // ---------------------------------------------------------------
   // shared state between stimulus, driver, receiver and scoreboard
   // ---------------------------------------------------------------
   noise_event_type pending_events[$];   // words waiting to be offered
   logic            level_expect[$];     // predicted noise bits, oldest first
   noise_event_type cur_event;           // word on the request bus
   logic            req_taken    = 1'b0; // request word accepted at the last rising edge
   logic            rsp_taken    = 1'b0; // response word accepted at the last rising edge
   int              send_gap_max = 0;
   int              recv_gap_max = 0;
   int              send_wait    = 0;
   int              recv_wait    = 0;
   int              hold_left    = 0;
   logic            hold_request = 1'b0; // asks the receiver for one long hold-off
   int              mismatch_count = 0;
   int              stall_count    = 0;

   // ---------------------------------------------------------------
   // request driver: changes the bus at the falling edge, draws a random
   // gap of at most send_gap_max after every accepted word
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (req_taken) send_wait = $urandom_range(0, send_gap_max);
         if (send_wait > 0) begin
            send_wait--;
            req_tvalid <= 1'b0;
         end else if (pending_events.size() != 0) begin
            cur_event = pending_events.pop_front();
            req_tuser  <= cur_event.kind;
            req_tdata  <= {5'b0, cur_event.new_rate_mode, cur_event.sync_on};
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // accepted request words run through the predictor right at the handshake
   always @(posedge clock) begin
      req_taken = !reset && req_tvalid && req_tready;
      if (req_taken) level_expect.push_back(next_noise_level(cur_event));
   end

   // ---------------------------------------------------------------
   // response receiver: random stalls after each word, plus one long
   // hold-off counted here so the voice backs up onto its input
   // ---------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_taken) recv_wait = $urandom_range(0, recv_gap_max);
         if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // scoreboard: each response word against the oldest prediction
   always @(posedge clock) begin
      rsp_taken = !reset && rsp_tvalid && rsp_tready;
      if (rsp_taken) begin
         if (level_expect.size() == 0) begin
            $display("%0t: response word with no prediction waiting, got %0b",
                     $time, rsp_tdata[0]);
            mismatch_count++;
         end else if (rsp_tdata[0] !== level_expect[0]) begin
            $display("%0t: noise_level mismatch, expected %0b, got %0b",
                     $time, level_expect[0], rsp_tdata[0]);
            mismatch_count++;
            void'(level_expect.pop_front());
         end else begin
            void'(level_expect.pop_front());
         end
      end
   end

   // watchdog on cycles with no handshake on either stream
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) stall_count = 0;
      else stall_count++;
      if (stall_count >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, stall_count);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------
   task automatic queue_event(input scng_pkg::kind_type k, input logic s,
                              input logic [1:0] m);
      noise_event_type ev;
      ev.kind          = k;
      ev.sync_on       = s;
      ev.new_rate_mode = m;
      pending_events.push_back(ev);
   endtask

   // register write, only issued while the voice is idle
   task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(posedge clock);
      case (idx)
         scng_pkg::CSR_SOURCE_MODE: src_sel = val[1:0];
         scng_pkg::CSR_GEN_KIND:    kind_sel = val[0];
         scng_pkg::CSR_SEED:        gen_reg = val;
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // sender pause: nothing left to offer and every response in
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_events.size() != 0 || req_tvalid || level_expect.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // mostly ticks or triggers depending on the source, some sync and rate words;
   // unused fields stay random so every bit toggles
   function automatic noise_event_type random_event(input logic [1:0] src);
      noise_event_type ev;
      int unsigned     roll;
      roll             = $urandom_range(0, 99);
      ev.sync_on       = 1'($urandom_range(0, 1));
      ev.new_rate_mode = 2'($urandom_range(0, 3));
      if (roll < ((src == scng_pkg::SOURCE_TRIGGER) ? 25 : 55)) begin
         ev.kind = scng_pkg::KIND_TICK;
      end else if (roll < 70) begin
         ev.kind = scng_pkg::KIND_TRIGGER;
      end else if (roll < 85) begin
         // sync on less often so the counter gets to run
         ev.kind    = scng_pkg::KIND_SYNC;
         ev.sync_on = ($urandom_range(0, 99) < 40);
      end else begin
         ev.kind = scng_pkg::KIND_RATE;
      end
      return ev;
   endfunction

   // ---------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------
   initial begin : stimulus
      logic [1:0]  src;
      logic [31:0] val;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: reset settings, internal clock at full rate, slowest sample rate
      send_gap_max = 0;
      recv_gap_max = 3;
      queue_event(scng_pkg::KIND_TICK, 1'b0, 2'd0);
      queue_event(scng_pkg::KIND_TICK, 1'b1, 2'd3);
      queue_event(scng_pkg::KIND_TICK, 1'b0, 2'd0);
      queue_event(scng_pkg::KIND_TRIGGER, 1'b1, 2'd3);   // ignored outside trigger mode
      queue_event(scng_pkg::KIND_RATE, 1'b0, 2'd0);      // counter scaled up by four
      queue_event(scng_pkg::KIND_TICK, 1'b0, 2'd0);
      queue_event(scng_pkg::KIND_RATE, 1'b1, 2'd3);      // rate mode 3 taken as 2
      queue_event(scng_pkg::KIND_RATE, 1'b0, 2'd1);
      queue_event(scng_pkg::KIND_TICK, 1'b0, 2'd2);
      queue_event(scng_pkg::KIND_SYNC, 1'b1, 2'd0);      // sync on clears the counter
      queue_event(scng_pkg::KIND_TICK, 1'b0, 2'd0);      // no counting while synced
      queue_event(scng_pkg::KIND_SYNC, 1'b0, 2'd3);
      queue_event(scng_pkg::KIND_TICK, 1'b0, 2'd0);
      wait_drained();

      // trigger mode with the shift register from an all-ones seed
      write_reg(scng_pkg::CSR_SOURCE_MODE, {30'd0, scng_pkg::SOURCE_TRIGGER});
      write_reg(scng_pkg::CSR_GEN_KIND, {31'd0, scng_pkg::GEN_LFSR});
      write_reg(scng_pkg::CSR_SEED, 32'hFFFF_FFFF);
      write_reg(CSR_UNUSED, 32'h0000_0002);    // must not touch any register
      queue_event(scng_pkg::KIND_TRIGGER, 1'b0, 2'd0);
      queue_event(scng_pkg::KIND_TRIGGER, 1'b0, 2'd0);
      queue_event(scng_pkg::KIND_TICK, 1'b0, 2'd0);      // tick only reports in trigger mode
      queue_event(scng_pkg::KIND_SYNC, 1'b1, 2'd0);
      queue_event(scng_pkg::KIND_TRIGGER, 1'b0, 2'd0);   // trigger still advances while synced
      queue_event(scng_pkg::KIND_SYNC, 1'b0, 2'd0);
      queue_event(scng_pkg::KIND_RATE, 1'b0, 2'd0);
      queue_event(scng_pkg::KIND_TRIGGER, 1'b1, 2'd2);
      wait_drained();

      // congruential level edge: a value of exactly 0x80000000 reads low
      write_reg(scng_pkg::CSR_SOURCE_MODE, 32'd0);
      write_reg(scng_pkg::CSR_GEN_KIND, {31'd0, scng_pkg::GEN_LCG});
      write_reg(scng_pkg::CSR_SEED, scng_pkg::LEVEL_EDGE);
      queue_event(scng_pkg::KIND_TICK, 1'b0, 2'd0);
      queue_event(scng_pkg::KIND_TICK, 1'b0, 2'd0);
      wait_drained();
      write_reg(scng_pkg::CSR_SEED, scng_pkg::LEVEL_EDGE + 32'd1);
      queue_event(scng_pkg::KIND_TICK, 1'b0, 2'd0);
      wait_drained();

      // kind switch keeps the generator value and the latched level
      write_reg(scng_pkg::CSR_GEN_KIND, {31'd0, scng_pkg::GEN_LFSR});
      queue_event(scng_pkg::KIND_TICK, 1'b0, 2'd0);
      queue_event(scng_pkg::KIND_TICK, 1'b0, 2'd0);
      wait_drained();

      // random phases, each with its own register settings and idling
      for (int phase = 0; phase < 12; phase++) begin
         if (phase == 0) src = 2'd0;
         else if (phase == 1) src = scng_pkg::SOURCE_TRIGGER;
         else src = 2'($urandom_range(0, 3));
         // upper data bits are junk, only the register width counts
         val      = $urandom;
         val[1:0] = src;
         write_reg(scng_pkg::CSR_SOURCE_MODE, val);
         write_reg(scng_pkg::CSR_GEN_KIND, $urandom);
         if (phase == 2) write_reg(scng_pkg::CSR_SEED, 32'h0000_0000);
         else if (phase == 3) write_reg(scng_pkg::CSR_SEED, 32'hFFFF_FFFF);
         else if ($urandom_range(0, 1)) write_reg(scng_pkg::CSR_SEED, $urandom);
         if ($urandom_range(0, 3) == 0) write_reg(CSR_UNUSED, $urandom);

         // phase 0 runs with no idling on either side
         send_gap_max = (phase % 3 == 0) ? 0 : 3;
         recv_gap_max = (phase % 4 == 0) ? 0 : 3;
         repeat (110) pending_events.push_back(random_event(src));

         // back-pressure: receiver stops while the sender keeps offering
         if (phase == 4) begin
            send_gap_max = 0;
            @(posedge clock);
            hold_request = 1'b1;
         end
         wait_drained();
      end

      if (mismatch_count == 0 && level_expect.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
